// ===== sv/nrw_pkg.sv =====
`default_nettype none

package nrw_pkg;

  localparam int NONCE_HALF_W = 64;
  localparam int NOW_W        = 32;
  localparam int EXPIRY_W     = 33;
  localparam int LIMIT_W      = 7;
  localparam int LIFETIME_W   = 20;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LIMIT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIFETIME     = 8'd1;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 7'd64;
  localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 20'd300;

  typedef enum logic {
    OP_CHECK   = 1'b0,
    OP_CLEANUP = 1'b1
  } op_t;

  typedef struct packed {
    logic [NONCE_HALF_W-1:0] nonce_high;
    logic [NONCE_HALF_W-1:0] nonce_low;
    logic [EXPIRY_W-1:0]     expiry;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic append;
    logic compare;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/nrw_cell.sv =====
`default_nettype none

module nrw_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire                                 clk,
  input  wire nrw_pkg::cell_ctrl_t            ctrl,
  input  wire [CW-1:0]                        count,
  input  wire nrw_pkg::entry_t                new_entry,
  input  wire nrw_pkg::entry_t                neighbor,
  output nrw_pkg::entry_t                     entry,
  output logic                                match
);

  logic occupied;

  assign occupied = CW'(IDX) < count;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= neighbor;
    end else if (ctrl.append && (CW'(IDX) == count)) begin
      entry <= new_entry;
    end
    if (ctrl.compare) begin
      match <= occupied && (entry.nonce_high == new_entry.nonce_high) &&
               (entry.nonce_low == new_entry.nonce_low);
    end
  end

endmodule

`default_nettype wire

// ===== sv/nonce_replay_window_top.sv =====
`default_nettype none

// Replay filter holding a first-in-first-out window of recent nonces in a row
// of cells, the oldest in the first cell; dropping an entry shifts every cell
// toward the front by one place, and a new nonce is written into the first
// free cell. The nonce is compared against all cells at once. A request
// carries opcode in tuser and the nonce halves and time in tdata; the result
// carries accepted in tuser and the occupancy in tdata. The block handles one
// request at a time and takes no new one until the result of the last is
// registered at the output. A replay leaves the window unchanged; a cleanup
// removes the expired entries; a fresh nonce removes them, then those over the
// size limit, and is appended. The shift sequencer removes one entry per cycle.
// The configuration channel is always ready and must only be written while idle.
module nonce_replay_window_top #(
  parameter int WINDOW_DEPTH = 64,
  parameter int NONCE_BYTES  = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [159:0] s_tdata,   // nonce_high, nonce_low, now_sec
  input  wire          s_tuser,   // opcode
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [7:0]   m_tdata,   // occupancy, one zero pad bit
  output logic         m_tuser,   // accepted
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [nrw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [nrw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = (CW > nrw_pkg::LIMIT_W) ? CW : nrw_pkg::LIMIT_W;
  localparam int NONCE_W = NONCE_BYTES * 8;
  localparam logic [127:0] NONCE_MASK =
    (NONCE_W >= 128) ? {128{1'b1}} : ((128'd1 << NONCE_W) - 128'd1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CMP    = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_EXPIRE = 7'b0001000,
    S_LIMIT  = 7'b0010000,
    S_APPEND = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [nrw_pkg::LIMIT_W-1:0]    window_limit;
  logic [nrw_pkg::LIFETIME_W-1:0] lifetime;
  logic [CW-1:0]                  count, count_next;
  nrw_pkg::op_t                   op;
  logic [nrw_pkg::NOW_W-1:0]      now;
  logic                           acc, acc_next;
  logic [nrw_pkg::LIMIT_W-1:0]    out_occ;
  logic                           out_acc;

  nrw_pkg::entry_t     new_entry;
  nrw_pkg::entry_t     cells [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] match_vec;
  nrw_pkg::cell_ctrl_t ctrl;

  logic [LW-1:0] limit_ext, depth_ext, limit_eff;
  logic          front_expired;
  logic          at_limit;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {1'b0, out_occ};
  assign m_tuser   = out_acc;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= nrw_pkg::LIMIT_RESET;
      lifetime     <= nrw_pkg::LIFETIME_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == nrw_pkg::REG_WINDOW_LIMIT) begin
        window_limit <= cfg_data[nrw_pkg::LIMIT_W-1:0];
      end else if (cfg_index == nrw_pkg::REG_LIFETIME) begin
        lifetime <= cfg_data[nrw_pkg::LIFETIME_W-1:0];
      end
    end
  end

  assign limit_ext = LW'(window_limit);
  assign depth_ext = LW'(WINDOW_DEPTH);
  assign limit_eff = (window_limit == '0) ? LW'(1) :
                     ((limit_ext > depth_ext) ? depth_ext : limit_ext);
  assign at_limit  = LW'(count) >= limit_eff;
  assign front_expired = (count != '0) && (cells[0].expiry < {1'b0, now});

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op                   <= nrw_pkg::op_t'(s_tuser);
      now                  <= s_tdata[159:128];
      new_entry.nonce_high <= s_tdata[63:0] & NONCE_MASK[127:64];
      new_entry.nonce_low  <= s_tdata[127:64] & NONCE_MASK[63:0];
    end
    if (state == S_DECIDE) begin
      new_entry.expiry <= {1'b0, now} + nrw_pkg::EXPIRY_W'(lifetime);
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    acc_next     = acc;
    ctrl         = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.compare = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        acc_next = 1'b0;
        if ((op == nrw_pkg::OP_CHECK) && (|match_vec)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        if (front_expired) begin
          ctrl.shift = 1'b1;
          count_next = count - CW'(1);
        end else if (op == nrw_pkg::OP_CLEANUP) begin
          state_next = S_DONE;
        end else begin
          state_next = S_LIMIT;
        end
      end
      S_LIMIT: begin
        if (at_limit) begin
          ctrl.shift = 1'b1;
          count_next = count - CW'(1);
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ctrl.append = 1'b1;
        count_next  = count + CW'(1);
        acc_next    = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      acc      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      acc   <= acc_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_acc <= acc;
      out_occ <= nrw_pkg::LIMIT_W'(count);
    end
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    nrw_pkg::entry_t neighbor;
    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign neighbor = '0;
    end else begin : g_link
      assign neighbor = cells[i+1];
    end
    nrw_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .new_entry (new_entry),
      .neighbor  (neighbor),
      .entry     (cells[i]),
      .match     (match_vec[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= depth_ext)
    else $error("window holds more entries than its depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the window by one");

  a_append_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> (LW'(count) < limit_eff))
    else $error("append with the window at its limit");

  a_fresh_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && acc) |-> (count != '0))
    else $error("fresh nonce reported with an empty window");
`endif

endmodule

`default_nettype wire
